// ===== src/gffp_pkg.sv =====
// ----------------------------------------------------------------------------
// gffp_pkg
// Shared constants and types for the grid first-fit placer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gffp_pkg;

  // Grid geometry
  localparam int GRID_ROWS = 15;
  localparam int GRID_COLS = 8;

  // Derived widths
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RUN_W  = 4;  // free-run counter, saturates at 15
  localparam int DIM_W  = 4;  // rect_width / rect_height field width
  localparam int SLOT_W = 7;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result of the per-row window search
  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
  } fit_res_t;

endpackage

// ===== src/gffp_fit.sv =====
// ----------------------------------------------------------------------------
// gffp_fit
// Window search over one grid row: finds the lowest column at which a run
// of rect_width columns all have enough free rows ending at the scan row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gffp_fit import gffp_pkg::*; (
  input  logic [GRID_COLS-1:0] col_ok_i,
  input  logic [DIM_W-1:0]     width_i,
  output fit_res_t             fit_o
);

  logic [GRID_COLS-1:0] win_ok;

  // Every window position, independent of the others
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      win_ok[c] = (int'(width_i) + c <= GRID_COLS);
      for (int k = 0; k < GRID_COLS; k++) begin
        if (k >= c && k < c + int'(width_i)) begin
          win_ok[c] = win_ok[c] & col_ok_i[k];
        end
      end
    end
  end

  // Lowest column wins
  always_comb begin
    fit_o.hit = 1'b0;
    fit_o.col = '0;
    for (int c = GRID_COLS - 1; c >= 0; c--) begin
      if (win_ok[c]) begin
        fit_o.hit = 1'b1;
        fit_o.col = COL_W'(c);
      end
    end
  end

endmodule

// ===== src/grid_first_fit_placer_unit.sv =====
// ----------------------------------------------------------------------------
// grid_first_fit_placer_unit
// First-fit rectangle placement in a 15 x 8 occupancy map held in memory.
// ----------------------------------------------------------------------------
// One word in, one word out. An allocate word scans the map one row per
// cycle out of a row memory with one read and one write port, keeping a
// free-run count per column, so a fit whose top row is r with height h is
// found on row r+h-1; the scan stops at the first hit. Marking then reads
// and writes back one row per cycle, h rows in all, and the done state
// hands the result to the output register. Clear and zero-size or
// oversized requests go straight to the done state. The memory read port
// sets the pace. Clear empties the map at once through per-row valid bits.
// A new word is taken while an earlier result still waits at the output.
`timescale 1ns / 1ps

module grid_first_fit_placer_unit import gffp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [DIM_W-1:0]  rect_width_i,
  input  logic [DIM_W-1:0]  rect_height_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [SLOT_W-1:0] slot_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MARK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

  // Control state
  logic [1:0]           state_q, state_d;
  logic [ROW_W-1:0]     j_q, j_d;
  logic [ROW_W-1:0]     wr_row_q, wr_row_d;
  logic [RUN_W-1:0]     cnt_q, cnt_d;
  logic [GRID_ROWS-1:0] valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;

  // Payload
  logic [DIM_W-1:0]     w_q, w_d, h_q, h_d;
  logic [RUN_W-1:0]     run_q [GRID_COLS];
  logic [RUN_W-1:0]     run_d [GRID_COLS];
  logic [GRID_COLS-1:0] span_q, span_d;
  logic                 res_found_q, res_found_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic                 found_q, found_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;

  // Row memory
  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data_q;
  logic                 rd_valid_q;
  logic [ROW_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [GRID_COLS-1:0] wr_data;

  // Datapath
  logic [GRID_COLS-1:0] row_bits;
  logic [RUN_W-1:0]     run_nxt [GRID_COLS];
  logic [GRID_COLS-1:0] col_ok;
  logic [GRID_COLS-1:0] w_mask;
  logic [ROW_W-1:0]     top_row;
  logic                 in_acc, out_acc, reject;
  fit_res_t             fit;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;

  // Unwritten rows read as free
  assign row_bits = rd_valid_q ? rd_data_q : '0;

  // Free-run count per column, saturating
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      if (row_bits[c]) begin
        run_nxt[c] = '0;
      end else if (run_q[c] == RUN_MAX) begin
        run_nxt[c] = RUN_MAX;
      end else begin
        run_nxt[c] = run_q[c] + 1'b1;
      end
      col_ok[c] = (run_nxt[c] >= RUN_W'(h_q));
      w_mask[c] = (c < int'(w_q));
    end
  end

  gffp_fit u_fit (
    .col_ok_i (col_ok),
    .width_i  (w_q),
    .fit_o    (fit)
  );

  assign top_row = ROW_W'(j_q + 1'b1 - ROW_W'(h_q));

  assign reject = (rect_width_i == '0) || (rect_height_i == '0) ||
                  (int'(rect_width_i) > GRID_COLS) ||
                  (int'(rect_height_i) > GRID_ROWS);

  // Memory write: read-modify-write of the row read last cycle
  assign wr_en   = (state_q == ST_MARK);
  assign wr_data = row_bits | span_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    wr_row_d    = wr_row_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    w_d         = w_q;
    h_d         = h_q;
    run_d       = run_q;
    span_d      = span_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    found_d     = found_q;
    slot_d      = slot_q;
    rd_addr     = '0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_found_d = 1'b0;
          res_slot_d  = '0;
          w_d         = rect_width_i;
          h_d         = rect_height_i;
          for (int c = 0; c < GRID_COLS; c++) begin
            run_d[c] = '0;
          end
          j_d = '0;
          if (operation_i == OP_CLEAR) begin
            valid_d = '0;
            state_d = ST_DONE;
          end else if (reject) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        run_d = run_nxt;
        if (fit.hit) begin
          rd_addr     = top_row;
          wr_row_d    = top_row;
          cnt_d       = RUN_W'(h_q);
          span_d      = w_mask << fit.col;
          res_found_d = 1'b1;
          res_slot_d  = SLOT_W'(int'(top_row) * GRID_COLS + int'(fit.col));
          state_d     = ST_MARK;
        end else if (j_q == LAST_ROW) begin
          state_d = ST_DONE;
        end else begin
          rd_addr = j_q + 1'b1;
          j_d     = j_q + 1'b1;
        end
      end
      ST_MARK: begin
        valid_d[wr_row_q] = 1'b1;
        if (cnt_q > RUN_W'(1)) begin
          rd_addr  = wr_row_q + 1'b1;
          wr_row_d = wr_row_q + 1'b1;
          cnt_d    = cnt_q - 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          slot_d      = res_slot_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign slot_o      = slot_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      wr_row_q    <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      wr_row_q    <= wr_row_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    w_q         <= w_d;
    h_q         <= h_d;
    run_q       <= run_d;
    span_q      <= span_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    found_q     <= found_d;
    slot_q      <= slot_d;
  end

  // Row memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_row_q] <= wr_data;
    end
    rd_data_q  <= mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

`ifndef ASSERT_OFF
  // A result word only appears out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("output word raised outside done state");

  // Not found always carries slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> slot_o == '0)
    else $error("nonzero slot without a placement");

  // Placed slot lies inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> int'(slot_o) < GRID_ROWS * GRID_COLS)
    else $error("slot outside grid");

  // While rows remain to mark, the read never targets the row being written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MARK && cnt_q > RUN_W'(1) |-> rd_addr != wr_row_q)
    else $error("mark read collides with write");

  // Marking never runs off the bottom of the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MARK |-> int'(wr_row_q) < GRID_ROWS)
    else $error("mark row beyond grid");
`endif

endmodule

// ===== bench/tb_grid_first_fit_placer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_grid_first_fit_placer_unit
// Self-checking bench for the grid first-fit placer.
// ----------------------------------------------------------------------------
// Keeps its own copy of the 15 x 8 occupancy map and predicts every
// placement word when the request word is accepted. Runs a directed set
// (full grid, full map, clear, zero and oversized sizes, skipped cells),
// then random traffic under several idle/stall mixes, and finally a long
// output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_first_fit_placer_unit;
  import gffp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } placement_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic              operation_i   = OP_ALLOC;
  logic [DIM_W-1:0]  rect_width_i  = '0;
  logic [DIM_W-1:0]  rect_height_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              found_o;
  logic [SLOT_W-1:0] slot_o;

  // predicted map, bit c of row r set when cell (r, c) is taken
  logic [GRID_COLS-1:0] occupancy [GRID_ROWS];
  placement_t           pending_placements [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold_cycles = 0;

  grid_first_fit_placer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .slot_o        (slot_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_grid_first_fit_placer_unit failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    if (error_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_val,
               got_val);
    error_count++;
  endtask

  // First-fit placement on the predicted map; updates the map.
  function automatic placement_t place_rect(input logic op, input logic [DIM_W-1:0] w,
                                            input logic [DIM_W-1:0] h);
    placement_t           res;
    logic [63:0]          wide_span;
    logic [GRID_COLS-1:0] span;
    logic                 fits;
    res = '0;
    if (op == OP_CLEAR) begin
      foreach (occupancy[r]) occupancy[r] = '0;
      return res;
    end
    if (w == 0 || h == 0) return res;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        if (occupancy[r][c]) continue;
        if (c + w > GRID_COLS || r + h > GRID_ROWS) continue;
        wide_span = ((64'd1 << w) - 64'd1) << c;
        span      = wide_span[GRID_COLS-1:0];
        fits      = 1'b1;
        for (int k = 0; k < h; k++)
          if ((occupancy[r+k] & span) != '0) fits = 1'b0;
        if (!fits) continue;
        for (int k = 0; k < h; k++) occupancy[r+k] |= span;
        res.found = 1'b1;
        res.slot  = SLOT_W'(r * GRID_COLS + c);
        return res;
      end
    end
    return res;
  endfunction

  // Offer one request word, with an optional idle gap first; valid stays high
  // after acceptance, so a back-to-back word follows with no gap.
  task automatic send_word(input logic op, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    rect_width_i  <= w;
    rect_height_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    pending_placements.push_back(place_rect(op, w, h));
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender pause: wait for every result, then for the block to settle
  task automatic drain_results();
    while (pending_placements.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly small allocations that fill the map, a few clears, some noise.
  task automatic pick_word(output logic op, output logic [DIM_W-1:0] w,
                           output logic [DIM_W-1:0] h);
    int roll;
    roll = $urandom_range(99);
    op   = OP_ALLOC;
    if (roll < 4) begin
      op = OP_CLEAR;
      w  = DIM_W'($urandom_range(0, 15));
      h  = DIM_W'($urandom_range(0, 15));
    end else if (roll < 14) begin
      w = DIM_W'($urandom_range(0, 15));
      h = DIM_W'($urandom_range(0, 15));
    end else begin
      w = DIM_W'(($urandom_range(99) < 70) ? $urandom_range(1, 3) : $urandom_range(1, 8));
      h = DIM_W'(($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(1, 15));
    end
  endtask

  // Output side: random stalls, or a long hold-off when asked for.
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      out_ready_i    <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk_i) begin
    placement_t exp_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_placements.size() == 0) begin
        report_mismatch("unexpected word, found", -1, found_o);
      end else begin
        exp_word = pending_placements.pop_front();
        if (found_o !== exp_word.found) report_mismatch("found", exp_word.found, found_o);
        if (slot_o !== exp_word.slot) report_mismatch("slot", exp_word.slot, slot_o);
      end
    end
  end

  task automatic run_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(OP_ALLOC, 4'd8, 4'd15);   // whole grid at once
    send_word(OP_ALLOC, 4'd1, 4'd1);    // map full
    send_word(OP_CLEAR, 4'd0, 4'd0);
    send_word(OP_ALLOC, 4'd1, 4'd1);
    send_word(OP_ALLOC, 4'd8, 4'd1);    // row 0 partly taken, drops to row 1
    send_word(OP_ALLOC, 4'd7, 4'd1);    // fills the rest of row 0
    send_word(OP_ALLOC, 4'd1, 4'd14);   // runs off the bottom
    send_word(OP_ALLOC, 4'd1, 4'd13);
    send_word(OP_ALLOC, 4'd0, 4'd5);    // zero width
    send_word(OP_ALLOC, 4'd3, 4'd0);    // zero height
    send_word(OP_ALLOC, 4'd9, 4'd1);    // wider than the grid
    send_word(OP_ALLOC, 4'd15, 4'd15);
    send_word(OP_ALLOC, 4'd8, 4'd15);
    send_word(OP_ALLOC, 4'd7, 4'd13);   // exactly the remaining block
    send_word(OP_ALLOC, 4'd1, 4'd1);
    send_word(OP_CLEAR, 4'd15, 4'd15);
    send_word(OP_ALLOC, 4'd8, 4'd15);
    send_word(OP_CLEAR, 4'd0, 4'd0);
    send_word(OP_ALLOC, 4'd5, 4'd2);
    send_word(OP_ALLOC, 4'd4, 4'd3);    // too wide beside the first one
    send_word(OP_ALLOC, 4'd3, 4'd2);
    send_word(OP_ALLOC, 4'd1, 4'd15);
    send_word(OP_ALLOC, 4'd2, 4'd12);
    send_word(OP_CLEAR, 4'd0, 4'd0);
    stop_sending();
    drain_results();
  endtask

  task automatic run_random_phase(input int n_words, input int idle_pct, input int stall_pct);
    logic             op;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_words) begin
      pick_word(op, w, h);
      send_word(op, w, h);
    end
    stop_sending();
    drain_results();
  endtask

  // Long output hold-off with a busy sender: the block fills and stalls.
  task automatic run_backpressure_case();
    logic             op;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_cycles = 400;
    repeat (60) begin
      pick_word(op, w, h);
      send_word(op, w, h);
    end
    stop_sending();
    drain_results();
  endtask

  initial begin
    foreach (occupancy[r]) occupancy[r] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed_cases();
    run_random_phase(200, 0, 0);
    run_random_phase(200, 68, 0);
    run_random_phase(200, 0, 68);
    run_random_phase(200, 10, 10);
    run_backpressure_case();

    if (pending_placements.size() != 0)
      report_mismatch("words still expected at end", 0, pending_placements.size());
    if (error_count == 0) begin
      $display("tb_grid_first_fit_placer_unit passed");
    end else begin
      $display("tb_grid_first_fit_placer_unit failed");
    end
    $finish;
  end

endmodule
